// ===== src/sbi_pkg.sv =====
`timescale 1ns / 1ps

package sbi_pkg;

  // default coordinate width, signed fixed point with 4 fraction bits
  localparam int COORD_BITS_DEF = 16;

  localparam int NUM_SIDES = 4;

  // box sides in test order; the code of the first side crossed is reported
  typedef enum logic [1:0] {
    SIDE_TOP    = 2'd0,
    SIDE_RIGHT  = 2'd1,
    SIDE_BOTTOM = 2'd2,
    SIDE_LEFT   = 2'd3
  } side_t;

endpackage

// ===== src/segment_box_intersect.sv =====
`timescale 1ns / 1ps

// Segment versus axis-aligned box crossing test, five register stages.
// Throughput: one request per cycle while in_stall is low; each stage moves on when
// its successor has room, so bubbles are squeezed out and a stall on the output loses
// and repeats nothing.
// Reset clears the stage valid bits only; the datapath registers are not reset.
module segment_box_intersect #(
  parameter int COORD_BITS = sbi_pkg::COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  // request channel
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [COORD_BITS-1:0] seg_start_x,
  input  logic signed [COORD_BITS-1:0] seg_start_y,
  input  logic signed [COORD_BITS-1:0] seg_end_x,
  input  logic signed [COORD_BITS-1:0] seg_end_y,
  input  logic signed [COORD_BITS-1:0] box_center_x,
  input  logic signed [COORD_BITS-1:0] box_center_y,
  input  logic        [COORD_BITS-2:0] box_width,
  input  logic        [COORD_BITS-2:0] box_height,
  // result channel
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         hit,
  output logic [1:0]                   first_edge
);

  // Width plan. Every point is doubled so that corners 2c +/- size are exact.
  localparam int DW = COORD_BITS + 1;  // doubled coordinate
  localparam int PW = COORD_BITS + 2;  // box corner
  localparam int UW = COORD_BITS + 2;  // segment direction
  localparam int VW = PW + 1;          // side direction and corner offset
  localparam int MW = 2 * VW;          // one product, exact
  localparam int XW = MW + 1;          // cross product, exact
  localparam int NS = sbi_pkg::NUM_SIDES;

  // ---------------------------------------------------------------------------
  // Flow control: a stage loads when it is empty or its successor loads.
  // ---------------------------------------------------------------------------
  logic v1, v2, v3, v4;
  logic en1, en2, en3, en4, en5;

  assign en5      = !out_valid || !out_stall;
  assign en4      = !v4 || en5;
  assign en3      = !v3 || en4;
  assign en2      = !v2 || en3;
  assign en1      = !v1 || en2;
  assign in_stall = !en1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (en1) v1        <= in_valid;
      if (en2) v2        <= v1;
      if (en3) v3        <= v2;
      if (en4) v4        <= v3;
      if (en5) out_valid <= v4;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: doubled segment end points and the four box corners.
  // ---------------------------------------------------------------------------
  logic signed [DW-1:0] s1_ax, s1_ay, s1_bx, s1_by;
  logic signed [PW-1:0] s1_left, s1_right, s1_top, s1_bottom;

  logic signed [DW-1:0]         cx2, cy2;
  logic signed [COORD_BITS-1:0] half_w, half_h;  // full size, zero extended

  assign cx2    = $signed({box_center_x, 1'b0});
  assign cy2    = $signed({box_center_y, 1'b0});
  assign half_w = $signed({1'b0, box_width});
  assign half_h = $signed({1'b0, box_height});

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_ax     <= $signed({seg_start_x, 1'b0});
      s1_ay     <= $signed({seg_start_y, 1'b0});
      s1_bx     <= $signed({seg_end_x, 1'b0});
      s1_by     <= $signed({seg_end_y, 1'b0});
      s1_left   <= PW'(cx2) - PW'(half_w);
      s1_right  <= PW'(cx2) + PW'(half_w);
      s1_top    <= PW'(cy2) - PW'(half_h);
      s1_bottom <= PW'(cy2) + PW'(half_h);
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: segment direction u, side direction v and offset w = c - a.
  // Sides run top (left to right), right (top to bottom),
  // bottom (right to left), left (bottom to top).
  // ---------------------------------------------------------------------------
  logic signed [PW-1:0] c_x [NS];
  logic signed [PW-1:0] c_y [NS];
  logic signed [PW-1:0] d_x [NS];
  logic signed [PW-1:0] d_y [NS];

  always_comb begin
    c_x[sbi_pkg::SIDE_TOP]    = s1_left;
    c_y[sbi_pkg::SIDE_TOP]    = s1_top;
    d_x[sbi_pkg::SIDE_TOP]    = s1_right;
    d_y[sbi_pkg::SIDE_TOP]    = s1_top;
    c_x[sbi_pkg::SIDE_RIGHT]  = s1_right;
    c_y[sbi_pkg::SIDE_RIGHT]  = s1_top;
    d_x[sbi_pkg::SIDE_RIGHT]  = s1_right;
    d_y[sbi_pkg::SIDE_RIGHT]  = s1_bottom;
    c_x[sbi_pkg::SIDE_BOTTOM] = s1_right;
    c_y[sbi_pkg::SIDE_BOTTOM] = s1_bottom;
    d_x[sbi_pkg::SIDE_BOTTOM] = s1_left;
    d_y[sbi_pkg::SIDE_BOTTOM] = s1_bottom;
    c_x[sbi_pkg::SIDE_LEFT]   = s1_left;
    c_y[sbi_pkg::SIDE_LEFT]   = s1_bottom;
    d_x[sbi_pkg::SIDE_LEFT]   = s1_left;
    d_y[sbi_pkg::SIDE_LEFT]   = s1_top;
  end

  logic signed [UW-1:0] s2_ux, s2_uy;
  logic signed [VW-1:0] s2_vx [NS];
  logic signed [VW-1:0] s2_vy [NS];
  logic signed [VW-1:0] s2_wx [NS];
  logic signed [VW-1:0] s2_wy [NS];

  always_ff @(posedge clk) begin
    if (en2) begin
      s2_ux <= UW'(s1_bx) - UW'(s1_ax);
      s2_uy <= UW'(s1_by) - UW'(s1_ay);
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: the six products of the three cross products, per side.
  // Stage 4: den = u x v, nt = w x v, ns = w x u.
  // Stage 5: range check of t and s against [0,1] and side priority.
  // ---------------------------------------------------------------------------
  logic signed [MW-1:0] s3_uxvy [NS];
  logic signed [MW-1:0] s3_uyvx [NS];
  logic signed [MW-1:0] s3_wxvy [NS];
  logic signed [MW-1:0] s3_wyvx [NS];
  logic signed [MW-1:0] s3_wxuy [NS];
  logic signed [MW-1:0] s3_wyux [NS];

  logic signed [XW-1:0] s4_den [NS];
  logic signed [XW-1:0] s4_nt  [NS];
  logic signed [XW-1:0] s4_ns  [NS];

  logic [NS-1:0] side_hit;

  for (genvar g = 0; g < NS; g++) begin : g_side
    logic den_pos, den_neg, nt_neg, ns_neg, nt_zero, ns_zero;

    always_ff @(posedge clk) begin
      if (en2) begin
        s2_vx[g] <= VW'(d_x[g]) - VW'(c_x[g]);
        s2_vy[g] <= VW'(d_y[g]) - VW'(c_y[g]);
        s2_wx[g] <= VW'(c_x[g]) - VW'(s1_ax);
        s2_wy[g] <= VW'(c_y[g]) - VW'(s1_ay);
      end
      if (en3) begin
        s3_uxvy[g] <= MW'(s2_ux) * MW'(s2_vy[g]);
        s3_uyvx[g] <= MW'(s2_uy) * MW'(s2_vx[g]);
        s3_wxvy[g] <= MW'(s2_wx[g]) * MW'(s2_vy[g]);
        s3_wyvx[g] <= MW'(s2_wy[g]) * MW'(s2_vx[g]);
        s3_wxuy[g] <= MW'(s2_wx[g]) * MW'(s2_uy);
        s3_wyux[g] <= MW'(s2_wy[g]) * MW'(s2_ux);
      end
      if (en4) begin
        s4_den[g] <= XW'(s3_uxvy[g]) - XW'(s3_uyvx[g]);
        s4_nt[g]  <= XW'(s3_wxvy[g]) - XW'(s3_wyvx[g]);
        s4_ns[g]  <= XW'(s3_wxuy[g]) - XW'(s3_wyux[g]);
      end
    end

    // t = nt/den and s = ns/den lie in [0,1]; compared by sign, no division.
    // A zero denominator (parallel or degenerate) is never a hit.
    assign den_neg = s4_den[g][XW-1];
    assign den_pos = !den_neg && (s4_den[g] != '0);
    assign nt_neg  = s4_nt[g][XW-1];
    assign ns_neg  = s4_ns[g][XW-1];
    assign nt_zero = (s4_nt[g] == '0);
    assign ns_zero = (s4_ns[g] == '0);

    assign side_hit[g] =
        (den_pos && !nt_neg && !ns_neg &&
         (s4_nt[g] <= s4_den[g]) && (s4_ns[g] <= s4_den[g])) ||
        (den_neg && (nt_neg || nt_zero) && (ns_neg || ns_zero) &&
         (s4_nt[g] >= s4_den[g]) && (s4_ns[g] >= s4_den[g]));
  end

  // first side in test order wins; no hit reports the top code
  sbi_pkg::side_t first_side;

  always_comb begin
    if (side_hit[sbi_pkg::SIDE_TOP]) begin
      first_side = sbi_pkg::SIDE_TOP;
    end else if (side_hit[sbi_pkg::SIDE_RIGHT]) begin
      first_side = sbi_pkg::SIDE_RIGHT;
    end else if (side_hit[sbi_pkg::SIDE_BOTTOM]) begin
      first_side = sbi_pkg::SIDE_BOTTOM;
    end else if (side_hit[sbi_pkg::SIDE_LEFT]) begin
      first_side = sbi_pkg::SIDE_LEFT;
    end else begin
      first_side = sbi_pkg::SIDE_TOP;
    end
  end

  always_ff @(posedge clk) begin
    if (en5) begin
      hit        <= |side_hit;
      first_edge <= first_side;
    end
  end

endmodule

// ===== sim/tb_segment_box_intersect.sv =====
`timescale 1ns / 1ps

module tb_segment_box_intersect;

  localparam int COORD_BITS = sbi_pkg::COORD_BITS_DEF;
  localparam int RANDOM_REQUESTS = 450;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic        [COORD_BITS-2:0] extent_t;

  // one request as it sits on the input ports
  typedef struct {
    coord_t  seg_start_x;
    coord_t  seg_start_y;
    coord_t  seg_end_x;
    coord_t  seg_end_y;
    coord_t  box_center_x;
    coord_t  box_center_y;
    extent_t box_width;
    extent_t box_height;
  } request_t;

  // Predicts the crossing verdict of every accepted request and matches results in order.
  class crossing_scoreboard;
    typedef struct {
      bit             hit;
      sbi_pkg::side_t side;
    } verdict_t;

    verdict_t    awaited_q[$];
    int unsigned errors = 0;

    // cross-product test of a-b against c-d, no division; den of zero means no crossing
    static function bit segments_meet(longint ax, longint ay, longint bx, longint by,
                                      longint cx, longint cy, longint dx, longint dy);
      longint ux, uy, vx, vy, wx, wy, den, nt, ns;
      ux = bx - ax;
      uy = by - ay;
      vx = dx - cx;
      vy = dy - cy;
      wx = cx - ax;
      wy = cy - ay;
      den = ux * vy - uy * vx;
      if (den == 0) return 1'b0;
      nt = wx * vy - wy * vx;
      ns = wx * uy - wy * ux;
      if (den < 0) begin
        den = -den;
        nt  = -nt;
        ns  = -ns;
      end
      return (nt >= 0) && (ns >= 0) && (nt <= den) && (ns <= den);
    endfunction

    // everything at double scale so that the corners stay on the integer grid
    function verdict_t predict(request_t r);
      verdict_t v;
      longint   ax, ay, bx, by, lft, rgt, top, bot;
      ax  = 2 * longint'(r.seg_start_x);
      ay  = 2 * longint'(r.seg_start_y);
      bx  = 2 * longint'(r.seg_end_x);
      by  = 2 * longint'(r.seg_end_y);
      lft = 2 * longint'(r.box_center_x) - longint'(r.box_width);
      rgt = 2 * longint'(r.box_center_x) + longint'(r.box_width);
      top = 2 * longint'(r.box_center_y) - longint'(r.box_height);
      bot = 2 * longint'(r.box_center_y) + longint'(r.box_height);
      v.hit  = 1'b1;
      v.side = sbi_pkg::SIDE_TOP;
      if (segments_meet(ax, ay, bx, by, lft, top, rgt, top))      v.side = sbi_pkg::SIDE_TOP;
      else if (segments_meet(ax, ay, bx, by, rgt, top, rgt, bot)) v.side = sbi_pkg::SIDE_RIGHT;
      else if (segments_meet(ax, ay, bx, by, rgt, bot, lft, bot)) v.side = sbi_pkg::SIDE_BOTTOM;
      else if (segments_meet(ax, ay, bx, by, lft, bot, lft, top)) v.side = sbi_pkg::SIDE_LEFT;
      else                                                        v.hit  = 1'b0;
      return v;
    endfunction

    function void note_request(request_t r);
      awaited_q.push_back(predict(r));
    endfunction

    function int outstanding();
      return awaited_q.size();
    endfunction

    function void check_result(logic got_hit, logic [1:0] got_side);
      verdict_t want;
      if (awaited_q.size() == 0) begin
        $display("%0t: result with nothing awaited (hit %b, first_edge %0d)",
                 $time, got_hit, got_side);
        errors++;
        return;
      end
      want = awaited_q.pop_front();
      if (got_hit !== want.hit) begin
        $display("%0t: hit expected %b, actual %b", $time, want.hit, got_hit);
        errors++;
      end
      if (got_side !== want.side) begin
        $display("%0t: first_edge expected %0d, actual %0d", $time, want.side, got_side);
        errors++;
      end
    endfunction
  endclass

  // all block inputs start at known values
  logic    clk;
  logic    rst = 1'b1;
  logic    in_valid = 1'b0;
  logic    in_stall;
  coord_t  seg_start_x = '0;
  coord_t  seg_start_y = '0;
  coord_t  seg_end_x = '0;
  coord_t  seg_end_y = '0;
  coord_t  box_center_x = '0;
  coord_t  box_center_y = '0;
  extent_t box_width = '0;
  extent_t box_height = '0;
  logic    out_valid;
  logic    out_stall = 1'b0;
  logic    hit;
  logic [1:0] first_edge;

  // high during the stretch where neither side idles
  logic calm = 1'b0;

  crossing_scoreboard sb = new();

  segment_box_intersect #(
    .COORD_BITS(COORD_BITS)
  ) dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .seg_start_x (seg_start_x),
    .seg_start_y (seg_start_y),
    .seg_end_x   (seg_end_x),
    .seg_end_y   (seg_end_y),
    .box_center_x(box_center_x),
    .box_center_y(box_center_y),
    .box_width   (box_width),
    .box_height  (box_height),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .hit         (hit),
    .first_edge  (first_edge)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // generous backstop, far beyond the slowest legal run
  initial begin
    #2000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // receiver: stalls at random with a chance of roughly 8 in 100, none while calm
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= !calm && ($urandom_range(0, 99) < 8);
    end
  end

  // result side: every accepted result is matched against the oldest prediction
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      sb.check_result(hit, first_edge);
    end
  end

  // ints are truncated to port width, so any 32-bit pattern is a legal request
  function automatic request_t make_request(int sx, int sy, int ex, int ey,
                                            int cx, int cy, int w, int h);
    request_t r;
    r.seg_start_x  = coord_t'(sx);
    r.seg_start_y  = coord_t'(sy);
    r.seg_end_x    = coord_t'(ex);
    r.seg_end_y    = coord_t'(ey);
    r.box_center_x = coord_t'(cx);
    r.box_center_y = coord_t'(cy);
    r.box_width    = extent_t'(w);
    r.box_height   = extent_t'(h);
    return r;
  endfunction

  function automatic int offset(int span);
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  // Mostly segments thrown around a box so that crossings are common; the rest is raw
  // noise over every bit, degenerate shapes, and endpoints snapped onto an edge.
  function automatic request_t random_request();
    int kind, cx, cy, w, h, span, sx, sy, ex, ey;
    kind = $urandom_range(0, 9);
    if (kind < 2) begin
      return make_request($urandom, $urandom, $urandom, $urandom,
                          $urandom, $urandom, $urandom, $urandom);
    end
    cx = offset(20000);
    cy = offset(20000);
    w  = $urandom_range(0, 4000);
    h  = $urandom_range(0, 4000);
    if (kind == 3 || $urandom_range(0, 1)) begin
      // even sizes put the edges on the input grid so endpoints can land on them
      w = w & ~1;
      h = h & ~1;
    end
    span = ((w > h) ? w : h) + 64;
    sx = cx + offset(span);
    sy = cy + offset(span);
    ex = cx + offset(span);
    ey = cy + offset(span);
    if (kind == 2) begin
      case ($urandom_range(0, 4))
        0: begin ex = sx; ey = sy; end
        1: w = 0;
        2: h = 0;
        3: ey = sy;
        default: ex = sx;
      endcase
    end else if (kind == 3) begin
      // touching: one end exactly on an edge line, sometimes on a corner
      case ($urandom_range(0, 4))
        0: ey = cy - h / 2;
        1: ex = cx + w / 2;
        2: sy = cy + h / 2;
        3: sx = cx - w / 2;
        default: begin ex = cx + w / 2; ey = cy - h / 2; end
      endcase
    end
    return make_request(sx, sy, ex, ey, cx, cy, w, h);
  endfunction

  // hold the request until the block takes it, then record the prediction
  task automatic send_request(input request_t r);
    in_valid     <= 1'b1;
    seg_start_x  <= r.seg_start_x;
    seg_start_y  <= r.seg_start_y;
    seg_end_x    <= r.seg_end_x;
    seg_end_y    <= r.seg_end_y;
    box_center_x <= r.box_center_x;
    box_center_y <= r.box_center_y;
    box_width    <= r.box_width;
    box_height   <= r.box_height;
    do @(posedge clk); while (in_stall);
    sb.note_request(r);
  endtask

  // sender idles now and then before a request, never while calm
  task automatic offer(input request_t r);
    if (!calm && $urandom_range(0, 99) < 4) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    send_request(r);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
  endtask

  // Box of reference: centre at the origin, 32 by 32, edges at +/-16.
  task automatic run_directed();
    offer(make_request(0, -100, 0, 100, 0, 0, 32, 32));       // through top and bottom
    offer(make_request(100, 0, -100, 0, 0, 0, 32, 32));       // from the right
    offer(make_request(0, 0, 0, 100, 0, 0, 32, 32));          // bottom only
    offer(make_request(0, 0, -100, 0, 0, 0, 32, 32));         // left only
    offer(make_request(-5, -5, 5, 5, 0, 0, 32, 32));          // wholly inside
    offer(make_request(100, 100, 200, 300, 0, 0, 32, 32));    // clear miss
    offer(make_request(17, -100, 17, 100, 0, 0, 32, 32));     // just past the right edge
    offer(make_request(0, -16, 0, -16, 0, 0, 32, 32));        // zero-length on an edge
    offer(make_request(-50, 0, 50, 0, 0, 0, 0, 32));          // zero-width box
    offer(make_request(-50, 0, 50, 0, 0, 0, 0, 0));           // point box
    offer(make_request(-50, -16, 50, -16, 0, 0, 32, 32));     // lying along the top
    offer(make_request(-50, 16, 50, 16, 0, 0, 32, 32));       // lying along the bottom
    offer(make_request(0, -100, 0, -16, 0, 0, 32, 32));       // ends on the top edge
    offer(make_request(0, 16, 0, 100, 0, 0, 32, 32));         // starts on the bottom edge
    offer(make_request(20, -20, 16, -16, 0, 0, 32, 32));      // touches a corner
    offer(make_request(-100, 5, -16, 5, 0, 0, 33, 33));       // odd sizes, half-unit edges
    offer(make_request(-100, 5, -17, 5, 0, 0, 33, 33));       // ends half a unit short
    offer(make_request(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767));
    offer(make_request(-32768, -32768, -32768, -32768, -32768, -32768, 0, 0));
    offer(make_request(-32768, 0, 32767, 0, 0, 0, 32767, 32767));
    offer(make_request(-32768, -32768, 32767, 32767, 0, 0, 32767, 32767));
    offer(make_request(32767, -32768, 32767, 32767, 32767, 0, 32767, 2));
    offer(make_request(-32768, -32768, -32768, 32767, -32768, -32768, 0, 32767));
    offer(make_request(-32768, 32767, 32767, -32768, 0, 0, 65535, 65535));
  endtask

  initial begin
    int n;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    run_directed();
    // sender holds off until the pipeline has emptied
    drain_results();

    for (n = 0; n < RANDOM_REQUESTS; n++) begin
      calm <= (n >= 150) && (n < 250);
      offer(random_request());
    end
    calm <= 1'b0;
    drain_results();

    // catch any stray result past the pipeline depth
    repeat (20) @(posedge clk);
    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== segment_box_intersect.f =====
src/sbi_pkg.sv
src/segment_box_intersect.sv
sim/tb_segment_box_intersect.sv
